/* rtl/cc20_pkg.sv */
// ChaCha20 stream XOR: shared types, constants and helpers.
// Used by cc20_arx, cc20_core, chacha20_stream_xor and the testbench; no dependencies.
package cc20_pkg;

  localparam int unsigned ROUNDS  = 20;
  localparam int unsigned ROUND_W = 5;
  localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);

  typedef logic [31:0]     word_t;
  typedef word_t [3:0]     row_t;   // one row of the 4x4 state, column 0 lowest
  typedef row_t  [3:0]     blk_t;   // word 4*r+c sits at [r][c]

  // "expand 32-byte k"
  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646e;
  localparam word_t SIGMA2 = 32'h7962_2d32;
  localparam word_t SIGMA3 = 32'h6b20_6574;

  // Four add-xor-rotate steps of a quarter round
  typedef enum logic [1:0] {
    STEP_A_D16 = 2'd0,  // a += b; d = rotl(d ^ a, 16)
    STEP_C_B12 = 2'd1,  // c += d; b = rotl(b ^ c, 12)
    STEP_A_D8  = 2'd2,  // a += b; d = rotl(d ^ a, 8)
    STEP_C_B7  = 2'd3   // c += d; b = rotl(b ^ c, 7)
  } step_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY01   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY23   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY45   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY67   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE2  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CTR     = 3'd6;

  // Rotate a row by n word positions: out[i] = in[(i + n) mod 4]
  function automatic row_t rot_row(row_t r, logic [1:0] n);
    row_t o;
    for (int i = 0; i < 4; i++) begin
      o[i] = r[2'(i) + n];
    end
    return o;
  endfunction

endpackage

/* rtl/chacha20_stream_xor.sv */
// ChaCha20 stream XOR top level: config registers, stream handshake, chunk
// position and block counter. Depends on cc20_pkg and cc20_core.
//
// ChaCha20 (96-bit nonce, 32-bit block counter) applied to a stream of 64-bit
// words, eight words per 64-byte block; word j of a block is XORed with
// keystream words 2j (low half) and 2j+1 (high half). tuser[0] on an input
// word restarts the message: the block counter reloads from counter_start and
// that word opens a new block. The counter steps after every eighth word and
// wraps at 2^32. The block is busy with one word at a time. A word that opens
// a block holds the input through a load, the 20 rounds, in which a single
// four-lane add-xor-rotate unit runs the four quarter-round steps in turn
// across all four columns, the add of the initial state and a handoff; any
// other word goes straight to the output register. Either kind of word also
// holds the input while the output register is full and not yet taken. A
// finished word waits in the output register while the next input
// word is taken. Configuration writes take effect at the next block start and
// must only be made while the block is idle. Keystream words live in the
// core's state registers, so no memory and no clearing pass is needed after
// reset.
module chacha20_stream_xor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [63:0] data_chunk
  input  logic [0:0]  s_axis_tuser_i,   // [0] restart
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] cipher_chunk
  output logic        m_axis_tlast_o    // block_end
);

  typedef enum logic [1:0] {T_IDLE, T_BLOCK, T_EMIT} top_state_e;

  // configuration registers
  logic [63:0] key01_q, key23_q, key45_q, key67_q, nonce01_q;
  logic [31:0] nonce2_q, ctr_start_q;

  top_state_e  state_q;
  logic [31:0] counter_q;
  logic [2:0]  pos_q;
  logic [63:0] data_q;
  logic        m_valid_q;
  logic        m_last_q;
  logic [63:0] m_data_q;

  logic           in_acc;
  logic           restart;
  logic           need_blk;
  logic           emit_ok;
  logic [31:0]    ctr_now;
  cc20_pkg::blk_t init_blk;
  cc20_pkg::blk_t ks;
  cc20_pkg::row_t ks_row;
  logic [63:0]    ks_pair;
  logic           core_done;

  assign s_axis_tready_o = (state_q == T_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign restart  = s_axis_tuser_i[0];
  // a restart or position zero means a fresh block
  assign need_blk = restart || (pos_q == 3'd0);
  assign emit_ok  = !m_valid_q || m_axis_tready_i;

  // counter seen by the core at load; it is in counter_q by the final add
  assign ctr_now = (in_acc && restart) ? ctr_start_q : counter_q;

  assign init_blk[0] = {cc20_pkg::SIGMA3, cc20_pkg::SIGMA2,
                        cc20_pkg::SIGMA1, cc20_pkg::SIGMA0};
  assign init_blk[1] = {key23_q[63:32], key23_q[31:0], key01_q[63:32], key01_q[31:0]};
  assign init_blk[2] = {key67_q[63:32], key67_q[31:0], key45_q[63:32], key45_q[31:0]};
  assign init_blk[3] = {nonce2_q, nonce01_q[63:32], nonce01_q[31:0], ctr_now};

  cc20_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && need_blk),
    .init_i  (init_blk),
    .ks_o    (ks),
    .done_o  (core_done)
  );

  // chunk j uses keystream words 2j, 2j+1 = row j/2, columns 2(j%2)+{0,1}
  assign ks_row  = ks[pos_q[2:1]];
  assign ks_pair = pos_q[0] ? ks_row[3:2] : ks_row[1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key01_q     <= '0;
      key23_q     <= '0;
      key45_q     <= '0;
      key67_q     <= '0;
      nonce01_q   <= '0;
      nonce2_q    <= '0;
      ctr_start_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cc20_pkg::CFG_KEY01:   key01_q     <= cfg_wdata_i;
        cc20_pkg::CFG_KEY23:   key23_q     <= cfg_wdata_i;
        cc20_pkg::CFG_KEY45:   key45_q     <= cfg_wdata_i;
        cc20_pkg::CFG_KEY67:   key67_q     <= cfg_wdata_i;
        cc20_pkg::CFG_NONCE01: nonce01_q   <= cfg_wdata_i;
        cc20_pkg::CFG_NONCE2:  nonce2_q    <= cfg_wdata_i[31:0];
        cc20_pkg::CFG_CTR:     ctr_start_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= T_IDLE;
      counter_q <= '0;
      pos_q     <= '0;
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
    end else begin
      if (state_q == T_EMIT && emit_ok) begin
        m_valid_q <= 1'b1;
        m_last_q  <= (pos_q == 3'd7);
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        T_IDLE: begin
          if (in_acc) begin
            if (restart) begin
              counter_q <= ctr_start_q;
              pos_q     <= '0;
            end
            state_q <= need_blk ? T_BLOCK : T_EMIT;
          end
        end
        T_BLOCK: begin
          if (core_done) begin
            state_q <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (emit_ok) begin
            pos_q <= pos_q + 3'd1;
            if (pos_q == 3'd7) begin
              counter_q <= counter_q + 32'd1;
            end
            state_q <= T_IDLE;
          end
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      data_q <= s_axis_tdata_i;
    end
    if (state_q == T_EMIT && emit_ok) begin
      m_data_q <= data_q ^ ks_pair;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

/* rtl/cc20_arx.sv */
// ChaCha20 shared ARX unit: four lanes of one add-xor-rotate step.
// Depends on cc20_pkg.
module cc20_arx (
  input  cc20_pkg::step_e step_i,
  input  cc20_pkg::row_t  x_i,
  input  cc20_pkg::row_t  y_i,
  input  cc20_pkg::row_t  z_i,
  output cc20_pkg::row_t  x_o,
  output cc20_pkg::row_t  z_o
);

  cc20_pkg::row_t sum;
  cc20_pkg::row_t mix;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum[i] = x_i[i] + y_i[i];
      mix[i] = z_i[i] ^ sum[i];
      case (step_i)
        cc20_pkg::STEP_A_D16: z_o[i] = {mix[i][15:0], mix[i][31:16]};
        cc20_pkg::STEP_C_B12: z_o[i] = {mix[i][19:0], mix[i][31:20]};
        cc20_pkg::STEP_A_D8:  z_o[i] = {mix[i][23:0], mix[i][31:24]};
        cc20_pkg::STEP_C_B7:  z_o[i] = {mix[i][24:0], mix[i][31:25]};
        default:              z_o[i] = mix[i];
      endcase
    end
  end

  assign x_o = sum;

endmodule

/* rtl/cc20_core.sv */
// ChaCha20 block function: state registers, round sequencer, final add.
// Depends on cc20_pkg and cc20_arx.
module cc20_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  cc20_pkg::blk_t init_i,   // must hold from start until done
  output cc20_pkg::blk_t ks_o,
  output logic           done_o
);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINAL} core_state_e;

  core_state_e                      state_q;
  logic [cc20_pkg::ROUND_W-1:0]     round_q;
  cc20_pkg::step_e                  step_q;
  logic                             done_q;
  cc20_pkg::blk_t                   work_q;
  cc20_pkg::blk_t                   step_res;
  cc20_pkg::blk_t                   work_d;

  logic           sel_ac;
  cc20_pkg::row_t x_row, y_row, z_row, x_new, z_new;

  // steps 0/2 work on rows a,b,d; steps 1/3 on rows c,d,b
  assign sel_ac = (step_q == cc20_pkg::STEP_A_D16) || (step_q == cc20_pkg::STEP_A_D8);
  assign x_row  = sel_ac ? work_q[0] : work_q[2];
  assign y_row  = sel_ac ? work_q[1] : work_q[3];
  assign z_row  = sel_ac ? work_q[3] : work_q[1];

  cc20_arx u_arx (
    .step_i (step_q),
    .x_i    (x_row),
    .y_i    (y_row),
    .z_i    (z_row),
    .x_o    (x_new),
    .z_o    (z_new)
  );

  always_comb begin
    step_res = work_q;
    if (sel_ac) begin
      step_res[0] = x_new;
      step_res[3] = z_new;
    end else begin
      step_res[2] = x_new;
      step_res[1] = z_new;
    end
    work_d = step_res;
    // end of a round: even rounds move diagonals into columns, odd move back
    if (step_q == cc20_pkg::STEP_C_B7) begin
      work_d[2] = cc20_pkg::rot_row(step_res[2], 2'd2);
      if (!round_q[0]) begin
        work_d[1] = cc20_pkg::rot_row(step_res[1], 2'd1);
        work_d[3] = cc20_pkg::rot_row(step_res[3], 2'd3);
      end else begin
        work_d[1] = cc20_pkg::rot_row(step_res[1], 2'd3);
        work_d[3] = cc20_pkg::rot_row(step_res[3], 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      round_q <= '0;
      step_q  <= cc20_pkg::STEP_A_D16;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        C_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            state_q <= C_ROUND;
            round_q <= '0;
            step_q  <= cc20_pkg::STEP_A_D16;
          end
        end
        C_ROUND: begin
          step_q <= cc20_pkg::step_e'(2'(step_q) + 2'd1);
          if (step_q == cc20_pkg::STEP_C_B7) begin
            if (round_q == cc20_pkg::ROUND_LAST) begin
              state_q <= C_FINAL;
            end else begin
              round_q <= round_q + {{(cc20_pkg::ROUND_W-1){1'b0}}, 1'b1};
            end
          end
        end
        C_FINAL: begin
          state_q <= C_IDLE;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= C_IDLE;
        end
      endcase
    end
  end

  // state words; after the final add they hold the keystream
  always_ff @(posedge clk_i) begin
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          work_q <= init_i;
        end
      end
      C_ROUND: begin
        work_q <= work_d;
      end
      C_FINAL: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            work_q[r][c] <= work_q[r][c] + init_i[r][c];
          end
        end
      end
      default: begin
        work_q <= work_q;
      end
    endcase
  end

  assign ks_o   = work_q;
  assign done_o = done_q;

endmodule

/* rtl/cc20_checker.sv */
// Port-level checks for chacha20_stream_xor, attached with bind.
// No package dependencies.
module cc20_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // words taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("second word taken while one is in work");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != 2'd0)
    else $error("output word without a matching input word");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two words held");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !s_axis_tready_o)
    else $error("input ready with output and work stage both full");

endmodule

bind chacha20_stream_xor cc20_checker u_cc20_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

/* test/chacha20_stream_xor_tb.sv */
// Self-checking testbench for chacha20_stream_xor: ChaCha20 keystream XOR on 64-bit words.
// Needs cc20_pkg (register indexes, sigma constants) and the chacha20_stream_xor RTL.
`timescale 1ns / 1ps

module chacha20_stream_xor_tb;
  import cc20_pkg::*;

  localparam int CYCLE_LIMIT = 800_000;
  localparam int SHOW_MAX    = 10;

  // One expected output word: cipher text and end-of-block flag
  typedef struct packed {
    logic [63:0] cipher;
    logic        last;
  } cipher_word_t;

  // Cipher predictor plus in-order checker. Holds its own copy of the
  // config registers, the block counter and the chunk position.
  class cipher_scoreboard;
    bit [31:0]    key_w [8];
    bit [31:0]    nonce_w [3];
    bit [31:0]    ctr_start;
    bit [31:0]    blk_ctr;
    bit [2:0]     pos;
    bit [31:0]    ks [16];
    bit [31:0]    mix [16];
    cipher_word_t cipher_q [$];
    int           taken;
    int           results;
    int           errors;

    function void set_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        CFG_KEY01:   {key_w[1], key_w[0]} = v;
        CFG_KEY23:   {key_w[3], key_w[2]} = v;
        CFG_KEY45:   {key_w[5], key_w[4]} = v;
        CFG_KEY67:   {key_w[7], key_w[6]} = v;
        CFG_NONCE01: {nonce_w[1], nonce_w[0]} = v;
        CFG_NONCE2:  nonce_w[2] = v[31:0];
        CFG_CTR:     ctr_start = v[31:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] rotl(bit [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter(int a, int b, int c, int d);
      mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
      mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
      mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
      mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
    endfunction

    // Sixteen keystream words for the current counter
    function void make_keystream();
      bit [31:0] init_w [16];
      init_w[0] = SIGMA0;
      init_w[1] = SIGMA1;
      init_w[2] = SIGMA2;
      init_w[3] = SIGMA3;
      for (int i = 0; i < 8; i++) init_w[4 + i] = key_w[i];
      init_w[12] = blk_ctr;
      for (int i = 0; i < 3; i++) init_w[13 + i] = nonce_w[i];
      mix = init_w;
      repeat (10) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) ks[i] = mix[i] + init_w[i];
    endfunction

    // Accepted plain word -> expected cipher word
    function void take_plain(logic [63:0] data, logic restart);
      cipher_word_t e;
      if (restart) begin
        blk_ctr = ctr_start;
        pos     = '0;
      end
      if (pos == 3'd0) make_keystream();
      e.cipher = data ^ {ks[2 * pos + 1], ks[2 * pos]};
      e.last   = (pos == 3'd7);
      cipher_q.push_back(e);
      if (e.last) blk_ctr++;
      pos++;
      taken++;
    endfunction

    function void flag(string what, logic [63:0] exp_v, logic [63:0] got_v);
      errors++;
      if (errors <= SHOW_MAX)
        $display("[%0t] %s mismatch: expected %h got %h", $time, what, exp_v, got_v);
    endfunction

    function void check_cipher(logic [63:0] cipher, logic last);
      cipher_word_t e;
      results++;
      if (cipher_q.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("[%0t] unexpected output word %h last %b", $time, cipher, last);
        return;
      end
      e = cipher_q.pop_front();
      if (e.cipher !== cipher) flag("cipher", e.cipher, cipher);
      if (e.last !== last) flag("tlast", 64'(e.last), 64'(last));
    endfunction

    function int pending();
      return cipher_q.size();
    endfunction

    function void close_out();
      if (cipher_q.size() != 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%0d expected words never came out", cipher_q.size());
      end
    endfunction
  endclass

  // DUT-facing signals; the driven ones are known from time zero
  logic        clk_i     = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_idx   = CFG_KEY01;
  logic [63:0] cfg_wdata = '0;
  logic        s_valid   = 1'b0;
  logic [63:0] s_data    = '0;
  logic [0:0]  s_user    = '0;
  logic        m_ready   = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [63:0] m_data;
  logic        m_last;

  cipher_scoreboard sb;
  bit gaps_on   = 1'b1;   // random idling on both sides
  bit held      = 1'b0;   // long receiver hold-off already done
  int hold_left = 0;
  int cycles    = 0;

  // Data extremes for the directed part and for sprinkling into random traffic
  logic [63:0] extreme_words [8] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
    64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
    64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00
  };

  always #5 clk_i = ~clk_i;

  chacha20_stream_xor u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),    // [63:0] data_chunk
    .s_axis_tuser_i  (s_user),    // [0] restart
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),    // [63:0] cipher_chunk
    .m_axis_tlast_o  (m_last)     // block_end
  );

  // Watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Output side: check words taken at this edge (pre-edge values), then pick
  // tready for the next cycle. Once, after a couple hundred words, tready is
  // held low for a long stretch so the core backs up and stalls its input.
  always @(posedge clk_i) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) sb.check_cipher(m_data, m_last);
      if (hold_left != 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (!held && sb.results >= 200) begin
        held      = 1'b1;
        hold_left = 600;
        m_ready  <= 1'b0;
      end else begin
        m_ready <= !(gaps_on && $urandom_range(0, 99) < 11);
      end
    end
  end

  // Offer one word and return at the edge that takes it. tvalid stays high
  // into the next call unless that call idles first.
  task automatic send_word(input logic [63:0] data, input logic restart);
    while (gaps_on && $urandom_range(0, 99) < 11) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= data;
    s_user  <= restart;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    sb.take_plain(data, restart);
  endtask

  // Stop offering and wait until every expected word has been checked
  task automatic drain();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One register write; cfg_we is left high for back-to-back writes
  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic program_regs(input logic [63:0] k01, k23, k45, k67, n01,
                              input logic [31:0] n2, ctr);
    cfg_write(CFG_KEY01, k01);
    cfg_write(CFG_KEY23, k23);
    cfg_write(CFG_KEY45, k45);
    cfg_write(CFG_KEY67, k67);
    cfg_write(CFG_NONCE01, n01);
    cfg_write(CFG_NONCE2, {32'h0, n2});
    cfg_write(CFG_CTR, {32'h0, ctr});
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          phase;
    int          goal;
    int          len;
    logic        first_rs;
    logic        rs;
    logic [63:0] data;
    logic [31:0] ctr;

    sb = new();
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // No restart after reset: zero key, counter zero, data extremes
    foreach (extreme_words[i]) send_word(extreme_words[i], 1'b0);
    drain();

    // Byte-ramp key, counter just below wrap. Restart three words into a
    // block abandons it; the full block at 0xFFFFFFFF is followed by block 0.
    program_regs(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
                 64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918,
                 64'h4a00_0000_0900_0000, 32'h0, 32'hFFFF_FFFF);
    send_word(extreme_words[1], 1'b1);
    send_word(extreme_words[2], 1'b0);
    send_word(extreme_words[3], 1'b0);
    send_word(extreme_words[0], 1'b1);
    for (int i = 1; i < 8; i++) send_word(extreme_words[i], 1'b0);
    send_word(extreme_words[0], 1'b0);
    drain();

    // Key change in mid-block: rest of the block keeps the old keystream
    cfg_write(CFG_KEY23, 64'hDEAD_BEEF_0123_4567);
    cfg_we <= 1'b0;
    for (int i = 4; i < 8; i++) send_word(extreme_words[i], 1'b0);

    // Random phases: new settings each time, then messages of random length.
    // Phase 0 all ones, phase 1 all zeros, phase 2 without idling.
    phase = 0;
    while (sb.taken < 1150) begin
      drain();
      ctr = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2) : $urandom();
      if (phase == 0)
        program_regs('1, '1, '1, '1, '1, '1, '1);
      else if (phase == 1)
        program_regs('0, '0, '0, '0, '0, '0, '0);
      else
        program_regs({$urandom(), $urandom()}, {$urandom(), $urandom()},
                     {$urandom(), $urandom()}, {$urandom(), $urandom()},
                     {$urandom(), $urandom()}, $urandom(), ctr);
      gaps_on = (phase != 2);
      goal = sb.taken + 100 + $urandom_range(0, 40);
      while (sb.taken < goal) begin
        len      = $urandom_range(1, 40);
        first_rs = ($urandom_range(0, 9) != 0);
        for (int k = 0; k < len; k++) begin
          // mostly clean messages, a few stray restarts as noise
          rs   = (k == 0) ? first_rs : ($urandom_range(0, 99) < 3);
          data = ($urandom_range(0, 19) == 0) ? extreme_words[$urandom_range(0, 7)]
                                              : {$urandom(), $urandom()};
          send_word(data, rs);
        end
      end
      phase++;
    end
    gaps_on = 1'b1;

    drain();
    repeat (120) @(posedge clk_i);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
